// ===== rtl/wfa_pkg.sv =====
package wfa_pkg;

    localparam int BLOCK_COUNT = 16;
    localparam int IDX_W       = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int CNT_W       = ($clog2(BLOCK_COUNT + 1) > 5) ? $clog2(BLOCK_COUNT + 1) : 5;
    localparam int CFG_W       = 5;
    localparam int SLOT_W      = 4;
    localparam int AMT_W       = 16;
    localparam int STAT_W      = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_ALLOCATE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_LOADED        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ALLOCATED     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOCATED = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } fsm_state_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic [AMT_W-1:0] best_val;
        logic [IDX_W-1:0] best_idx;
        logic [AMT_W-1:0] amount;
    } scan_tok_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [AMT_W-1:0] data;
    } wr_cmd_t;

endpackage

// ===== rtl/wfa_req_if.sv =====
interface wfa_req_if;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [wfa_pkg::SLOT_W-1:0] slot;
    logic [wfa_pkg::AMT_W-1:0]  amount;

    modport source (output valid, output command, output slot, output amount, input ready);
    modport sink (input valid, input command, input slot, input amount, output ready);
endinterface

// ===== rtl/wfa_rsp_if.sv =====
interface wfa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [wfa_pkg::STAT_W-1:0] status;
    logic [wfa_pkg::SLOT_W-1:0] chosen_slot;
    logic [wfa_pkg::AMT_W-1:0]  left_over;

    modport source (output valid, output status, output chosen_slot, output left_over,
                    input ready);
    modport sink (input valid, input status, input chosen_slot, input left_over,
                  output ready);
endinterface

// ===== rtl/wfa_cfg_if.sv =====
interface wfa_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [wfa_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/wfa_cell.sv =====
module wfa_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [wfa_pkg::IDX_W-1:0] cell_idx,
    input  logic [wfa_pkg::CNT_W-1:0] limit,
    input  wfa_pkg::wr_cmd_t         wr,
    input  wfa_pkg::scan_tok_t       tok_in,
    output wfa_pkg::scan_tok_t       tok_out
);
    import wfa_pkg::*;

    logic [AMT_W-1:0] free_reg;
    logic [AMT_W-1:0] free_next;
    scan_tok_t        tok_reg;
    scan_tok_t        tok_next;
    logic             in_scan;
    logic             take;

    assign in_scan = CNT_W'(cell_idx) < limit;

    always_comb
    begin
        take = tok_in.valid && in_scan && (free_reg >= tok_in.amount)
               && (!tok_in.found || (free_reg > tok_in.best_val));
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found    = 1'b1;
            tok_next.best_val = free_reg;
            tok_next.best_idx = cell_idx;
        end
    end

    always_comb
    begin
        free_next = free_reg;
        if (wr.en && (wr.idx == cell_idx))
        begin
            free_next = wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            free_reg <= free_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/worst_fit_allocator.sv =====
// worst-fit block allocator
//
// req channel: command, slot, amount. a load transfer writes one block's
// free size; an allocate scans blocks 0 .. min(blocks_in_use, 16)-1 for
// the largest free size not below amount, lowest index on ties, and subtracts.
// rsp channel: status, chosen_slot, left_over, one transfer per request.
// cfg channel: blocks_in_use, user writes it only while the block is idle; not enforced.
//
// a load passes through the result register and then the response
// register; an allocate first walks a scan token along the row of block
// cells, one cell per cycle, then passes through the same registers. one
// request is in work at a time; the next request is taken once the result
// sits in the response register.
//
// reset clears every block to zero and sets blocks_in_use to 16.
// when rsp stalls, the response register holds its transfer; one more
// finished result waits inside and no new request is taken until it moves.
module worst_fit_allocator (
    input  logic      clk,
    input  logic      rst_n,
    wfa_req_if.sink   req,
    wfa_rsp_if.source rsp,
    wfa_cfg_if.sink   cfg
);
    import wfa_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic [CFG_W-1:0]  blocks_in_use_reg;
    logic [CNT_W-1:0]  limit;

    logic              req_fire;
    logic              out_load;
    logic              scan_done;

    logic [STAT_W-1:0] res_status_reg;
    logic [STAT_W-1:0] res_status_next;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [SLOT_W-1:0] res_slot_next;
    logic [AMT_W-1:0]  res_left_reg;
    logic [AMT_W-1:0]  res_left_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [AMT_W-1:0]  out_left_reg;

    logic [AMT_W-1:0]  alloc_left;
    wr_cmd_t           wr;
    scan_tok_t         tok_head;
    scan_tok_t         chain [BLOCK_COUNT+1];

    assign limit = (CNT_W'(blocks_in_use_reg) > CNT_W'(BLOCK_COUNT))
                   ? CNT_W'(BLOCK_COUNT) : CNT_W'(blocks_in_use_reg);

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= CFG_RESET;
        end
        else if (cfg.valid)
        begin
            blocks_in_use_reg <= cfg.data;
        end
    end

    assign req_fire  = req.valid && req.ready;
    assign scan_done = chain[BLOCK_COUNT].valid;
    assign alloc_left = chain[BLOCK_COUNT].best_val - chain[BLOCK_COUNT].amount;

    // row of block cells
    always_comb
    begin
        tok_head.valid    = req_fire && (req.command == CMD_ALLOCATE);
        tok_head.found    = 1'b0;
        tok_head.best_val = '0;
        tok_head.best_idx = '0;
        tok_head.amount   = req.amount;
    end

    assign chain[0] = tok_head;

    for (genvar g = 0; g < BLOCK_COUNT; g++)
    begin : g_cell
        wfa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .limit    (limit),
            .wr       (wr),
            .tok_in   (chain[g]),
            .tok_out  (chain[g+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.command == CMD_ALLOCATE) ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the controller
    always_comb
    begin
        req.ready       = 1'b0;
        out_load        = 1'b0;
        wr.en           = 1'b0;
        wr.idx          = IDX_W'(req.slot);
        wr.data         = req.amount;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_left_next   = res_left_reg;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && (req.command == CMD_LOAD))
                begin
                    wr.en           = CNT_W'(req.slot) < CNT_W'(BLOCK_COUNT);
                    res_status_next = STAT_LOADED;
                    res_slot_next   = '0;
                    res_left_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    wr.idx  = chain[BLOCK_COUNT].best_idx;
                    wr.data = alloc_left;
                    if (chain[BLOCK_COUNT].found)
                    begin
                        wr.en           = 1'b1;
                        res_status_next = STAT_ALLOCATED;
                        res_slot_next   = SLOT_W'(chain[BLOCK_COUNT].best_idx);
                        res_left_next   = alloc_left;
                    end
                    else
                    begin
                        res_status_next = STAT_NOT_ALLOCATED;
                        res_slot_next   = '0;
                        res_left_next   = '0;
                    end
                end
            end
            S_RESP:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_left_reg   <= res_left_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_left_reg   <= res_left_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.chosen_slot = out_slot_reg;
    assign rsp.left_over   = out_left_reg;

    a_no_token_when_idle : assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg != S_SCAN) |-> !chain[BLOCK_COUNT].valid
    ) else $error("scan token outside of a scan");

    a_chosen_fits : assert property (
        @(posedge clk) disable iff (!rst_n)
        (scan_done && chain[BLOCK_COUNT].found)
            |-> (chain[BLOCK_COUNT].best_val >= chain[BLOCK_COUNT].amount)
    ) else $error("chosen block smaller than request");

    a_write_in_work : assert property (
        @(posedge clk) disable iff (!rst_n)
        wr.en |-> ((state_reg == S_IDLE && req_fire) || (state_reg == S_SCAN && scan_done))
    ) else $error("block write outside a request");

    a_alloc_starts_scan : assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_fire && req.command == CMD_ALLOCATE) |=> (state_reg == S_SCAN)
    ) else $error("allocate did not start a scan");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wfa_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * (BLOCK_COUNT + 2) + 4;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] chosen_slot;
        logic [AMT_W-1:0]  left_over;
    } outcome_t;

    logic clk;
    logic rst_n;

    wfa_req_if req_bus();
    wfa_rsp_if rsp_bus();
    wfa_cfg_if cfg_bus();

    worst_fit_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    logic [AMT_W-1:0] slot_room [BLOCK_COUNT];
    logic [CFG_W-1:0] scan_len;
    outcome_t         pending_outcomes[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;
    int fault_count;
    int requests_sent;
    int loads_seen;
    int grants_seen;
    int refusals_seen;
    int scan_writes;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // expected outcome of one request, updates the table copy
    function automatic outcome_t predict_outcome(input logic command,
                                                 input logic [SLOT_W-1:0] slot,
                                                 input logic [AMT_W-1:0] amount);
        outcome_t res;
        int       span;
        int       best;
        bit       found;
        res   = '0;
        best  = 0;
        found = 1'b0;
        if (command == CMD_LOAD)
        begin
            if (slot < BLOCK_COUNT)
                slot_room[slot] = amount;
            res.status = STAT_LOADED;
            return res;
        end
        span = (scan_len > BLOCK_COUNT) ? BLOCK_COUNT : int'(scan_len);
        for (int j = 0; j < span; j++)
        begin
            if (slot_room[j] >= amount && (!found || slot_room[j] > slot_room[best]))
            begin
                best  = j;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            res.status = STAT_NOT_ALLOCATED;
            return res;
        end
        slot_room[best]  = slot_room[best] - amount;
        res.status       = STAT_ALLOCATED;
        res.chosen_slot  = SLOT_W'(best);
        res.left_over    = slot_room[best];
        return res;
    endfunction

    function automatic void report_fault(input string what, input outcome_t want,
                                         input outcome_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t %s: expected status %0d slot %0d left %0d, got status %0d slot %0d left %0d",
                     $realtime, what, want.status, want.chosen_slot, want.left_over,
                     got.status, got.chosen_slot, got.left_over);
    endfunction

    task automatic send_request(input logic command, input logic [SLOT_W-1:0] slot,
                                input logic [AMT_W-1:0] amount);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid   <= 1'b1;
        req_bus.command <= command;
        req_bus.slot    <= slot;
        req_bus.amount  <= amount;
        do
            @(posedge clk);
        while (!(req_bus.valid && req_bus.ready));
        pending_outcomes.push_back(predict_outcome(command, slot, amount));
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_scan_length(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        scan_len = value;
        scan_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [AMT_W-1:0] amt;
        int               pick;
        int               j;
        int               mode;
        pick = $urandom_range(99);
        j    = $urandom_range(BLOCK_COUNT - 1);
        mode = $urandom_range(3);
        if (pick < 40)
        begin
            if (mode == 0)
                amt = '0;
            else if (mode == 1)
                amt = '1;
            else
                amt = AMT_W'($urandom);
            send_request(CMD_LOAD, SLOT_W'($urandom_range(15)), amt);
        end
        else if (pick < 92)
        begin
            if (mode == 0)
                amt = AMT_W'($urandom);
            else if (mode == 1)
                amt = slot_room[j] + 1'b1;
            else
                amt = AMT_W'($urandom_range(0, slot_room[j]));
            send_request(CMD_ALLOCATE, SLOT_W'($urandom), amt);
        end
        else
        begin
            send_request(1'($urandom), SLOT_W'($urandom), AMT_W'($urandom));
        end
    endtask

    task automatic test_corner_requests();
        send_request(CMD_ALLOCATE, 4'd5, 16'h0000);
        send_request(CMD_ALLOCATE, 4'd0, 16'h0001);
        send_request(CMD_ALLOCATE, 4'd15, 16'hFFFF);
        send_request(CMD_LOAD, 4'd0, 16'hFFFF);
        send_request(CMD_LOAD, 4'd15, 16'hFFFF);
        send_request(CMD_ALLOCATE, 4'd0, 16'hFFFF);
        send_request(CMD_ALLOCATE, 4'd0, 16'hFFFF);
        send_request(CMD_LOAD, 4'd3, 16'h5555);
        send_request(CMD_LOAD, 4'd9, 16'hAAAA);
        send_request(CMD_LOAD, 4'd12, 16'hAAAA);
        send_request(CMD_ALLOCATE, 4'd10, 16'h0000);
        send_request(CMD_ALLOCATE, 4'd5, 16'hAAAB);
        send_request(CMD_ALLOCATE, 4'd0, 16'h5555);
        send_request(CMD_ALLOCATE, 4'd0, 16'h0001);
        send_request(CMD_ALLOCATE, 4'd0, 16'hAAA9);
        send_request(CMD_ALLOCATE, 4'd0, 16'h5555);
        send_request(CMD_ALLOCATE, 4'd0, 16'h0001);
        send_request(CMD_LOAD, 4'd10, 16'h8000);
        send_request(CMD_LOAD, 4'd5, 16'h7FFF);
        send_request(CMD_ALLOCATE, 4'd15, 16'h7FFF);
    endtask

    task automatic test_scan_lengths();
        logic [CFG_W-1:0] lengths [6];
        lengths = '{5'd0, 5'd1, 5'd31, 5'd17, 5'd8, 5'd16};
        foreach (lengths[k])
        begin
            write_scan_length(lengths[k]);
            repeat (4)
                send_request(CMD_LOAD, SLOT_W'($urandom), AMT_W'($urandom));
            send_request(CMD_LOAD, 4'd0, AMT_W'($urandom));
            send_request(CMD_LOAD, 4'd15, AMT_W'($urandom));
            repeat (6)
                send_request(CMD_ALLOCATE, SLOT_W'($urandom), AMT_W'($urandom_range(16'h3FFF)));
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        write_scan_length(CFG_W'($urandom_range(16, 1)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            random_request();
        wait_drained();
    endtask

    task automatic test_backpressure();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_left = 300;
        repeat (24)
            random_request();
        wait_drained();
    endtask

    // receiver readiness, with long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        outcome_t got;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = '{rsp_bus.status, rsp_bus.chosen_slot, rsp_bus.left_over};
            if (got.status == STAT_LOADED)
                loads_seen++;
            else if (got.status == STAT_ALLOCATED)
                grants_seen++;
            else
                refusals_seen++;
            if (pending_outcomes.size() == 0)
                report_fault("result with nothing expected", '0, got);
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status)
                    report_fault("status mismatch", want, got);
                if (got.chosen_slot !== want.chosen_slot)
                    report_fault("chosen_slot mismatch", want, got);
                if (got.left_over !== want.left_over)
                    report_fault("left_over mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_outcomes.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        req_bus.valid   = 1'b0;
        req_bus.command = CMD_LOAD;
        req_bus.slot    = '0;
        req_bus.amount  = '0;
        rsp_bus.ready   = 1'b0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.data    = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        fault_count     = 0;
        requests_sent   = 0;
        loads_seen      = 0;
        grants_seen     = 0;
        refusals_seen   = 0;
        scan_writes     = 0;
        scan_len        = CFG_RESET;
        foreach (slot_room[k])
            slot_room[k] = '0;

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_requests();
        test_scan_lengths();
        test_random_traffic(0, 0, 310);
        test_random_traffic(71, 0, 310);
        test_random_traffic(0, 71, 310);
        test_random_traffic(37, 37, 310);
        test_backpressure();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_fault("expected result never arrived", pending_outcomes[0], '0);

        $display("covered %0d requests: %0d loads, %0d allocations, %0d refusals",
                 requests_sent, loads_seen, grants_seen, refusals_seen);
        $display("%0d scan length writes including 0 and 31, idle and stall mixes, one long hold-off",
                 scan_writes);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
